// ===== hw/rtl/assert_macros.svh =====
// Shared assertion macros for the RTL. Every check is sampled on i_clk and
// is switched off while the synchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lkv_pkg.sv =====
package lkv_pkg;

    // Widths fixed by the command word and the configuration register.
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Command codes.
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// ===== hw/rtl/lkv_ram.sv =====
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lru_key_value_cache_unit.sv =====
// A get word is accepted on start; its result strobe is registered from the finishing state.
// Busy holds from acceptance until the word is finished, and no new word is taken meanwhile.
// Each word takes one pass over the key and value memories through a single comparator.
// A set word produces no result; the receiver cannot stall and takes each result strobe.
// Reset is synchronous and active low: it empties the cache and sets capacity to 16.
// No clearing pass runs after reset; valid bits gate every stored key and value.
`include "assert_macros.svh"

module lru_key_value_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]       i_cfg_wdata,
    input  logic                            i_cmd,
    input  logic signed [lkv_pkg::KEY_W-1:0] i_lookup_key,
    input  logic signed [lkv_pkg::VAL_W-1:0] i_write_value,
    output logic                            o_strobe,
    output logic                            o_found,
    output logic signed [lkv_pkg::VAL_W-1:0] o_read_value
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    lkv_pkg::t_state r_state, n_state;

    // Configuration and per-entry control state.
    logic [lkv_pkg::CAP_W-1:0] r_cap;
    logic [ENTRIES-1:0]        r_valid, n_valid;
    logic [IW-1:0]             r_rank [ENTRIES];
    logic [IW-1:0]             n_rank [ENTRIES];
    logic [CW-1:0]             r_count, n_count;

    // Latched command word.
    logic                      r_cmd;
    logic [lkv_pkg::KEY_W-1:0] r_key;
    logic [lkv_pkg::VAL_W-1:0] r_val;

    // Scan pointer and the results gathered over the pass.
    logic [IW-1:0]             r_chk_idx;
    logic                      r_hit;
    logic [IW-1:0]             r_hit_idx;
    logic [IW-1:0]             r_hit_rank;
    logic [lkv_pkg::VAL_W-1:0] r_hit_val;
    logic                      r_free_ok;
    logic [IW-1:0]             r_free_idx;
    logic [IW-1:0]             r_vic_idx;

    // Result registers.
    logic                      r_strobe;
    logic                      r_found;
    logic [lkv_pkg::VAL_W-1:0] r_rdval;

    logic                      accept;
    logic [IW-1:0]             raddr;
    logic [lkv_pkg::KEY_W-1:0] key_rdata;
    logic [lkv_pkg::VAL_W-1:0] val_rdata;
    logic                      chk_valid;
    logic                      key_match;
    logic                      vic_match;
    logic [EW-1:0]             eff_cap;
    logic                      do_set;
    logic                      evict;
    logic                      ins;
    logic [IW-1:0]             slot;
    logic                      key_we;
    logic                      val_we;
    logic [IW-1:0]             val_waddr;
    logic                      fin_get;

    assign busy   = (r_state != lkv_pkg::ST_IDLE);
    assign accept = start && !busy;

    // The read address runs one entry ahead of the compare stage.
    assign raddr = (r_state != lkv_pkg::ST_SCAN || r_chk_idx == LAST_IDX) ?
                   '0 : r_chk_idx + 1'b1;

    lkv_ram #(.WIDTH(lkv_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (slot),
        .i_wdata (r_key),
        .i_raddr (raddr),
        .o_rdata (key_rdata)
    );

    lkv_ram #(.WIDTH(lkv_pkg::VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_val),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    // Shared compare unit: one entry is checked per scan cycle.
    assign chk_valid = r_valid[r_chk_idx];
    assign key_match = chk_valid && (key_rdata == r_key);
    assign vic_match = chk_valid && (CW'(r_rank[r_chk_idx]) == r_count - 1'b1);

    // A get word in its finishing cycle raises the result strobe next.
    assign fin_get = (r_state == lkv_pkg::ST_FINISH) && (r_cmd == lkv_pkg::CMD_GET);

    // Capacity saturates to the range one through ENTRIES.
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = EW'(1);
        end else if (EW'(r_cap) > EW'(ENTRIES)) begin
            eff_cap = EW'(ENTRIES);
        end else begin
            eff_cap = EW'(r_cap);
        end
    end

    // Decisions for the finishing cycle.
    always_comb begin
        do_set = (r_cmd == lkv_pkg::CMD_SET);
        evict  = do_set && !r_hit && (EW'(r_count) >= eff_cap);
        if (evict) begin
            slot = (r_free_ok && r_free_idx < r_vic_idx) ? r_free_idx : r_vic_idx;
            ins  = 1'b1;
        end else begin
            slot = r_free_idx;
            ins  = do_set && !r_hit && r_free_ok;
        end
        key_we    = (r_state == lkv_pkg::ST_FINISH) && ins;
        val_we    = (r_state == lkv_pkg::ST_FINISH) && do_set && (r_hit || ins);
        val_waddr = r_hit ? r_hit_idx : slot;
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lkv_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN: begin
                if (r_chk_idx == LAST_IDX) begin
                    n_state = lkv_pkg::ST_FINISH;
                end
            end
            lkv_pkg::ST_FINISH: begin
                n_state = lkv_pkg::ST_IDLE;
            end
            default: begin
                n_state = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    // Recency, valid and count update, applied to every entry at once.
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (r_state == lkv_pkg::ST_FINISH) begin
            if (r_hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == r_hit_idx) begin
                        n_rank[i] = '0;
                    end else if (r_valid[i] && r_rank[i] < r_hit_rank) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
            end else if (ins) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == slot) begin
                        n_valid[i] = 1'b1;
                        n_rank[i]  = '0;
                    end else if (evict && IW'(i) == r_vic_idx) begin
                        n_valid[i] = 1'b0;
                        n_rank[i]  = '0;
                    end else if (r_valid[i]) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
                if (!evict) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lkv_pkg::ST_IDLE;
            r_cap    <= lkv_pkg::CAP_RESET;
            r_valid  <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_strobe <= fin_get;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // Command latch and scan tracking.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_key     <= i_lookup_key;
            r_val     <= i_write_value;
            r_chk_idx <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_free_idx <= '0;
            r_vic_idx <= '0;
        end else if (r_state == lkv_pkg::ST_SCAN) begin
            if (r_chk_idx != LAST_IDX) begin
                r_chk_idx <= r_chk_idx + 1'b1;
            end
            if (key_match && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_chk_idx;
                r_hit_rank <= r_rank[r_chk_idx];
                r_hit_val  <= val_rdata;
            end
            if (!chk_valid && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_chk_idx;
            end
            if (vic_match) begin
                r_vic_idx <= r_chk_idx;
            end
        end
        if (r_state == lkv_pkg::ST_FINISH) begin
            r_found <= r_hit;
            r_rdval <= r_hit ? r_hit_val : '1;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_found      = r_found;
    assign o_read_value = r_rdval;

    `ASSERT_ALWAYS(a_count_matches_valid, $countones(r_valid) == int'(r_count), "count differs from valid bits")
    `ASSERT_IMPLY(a_miss_all_ones, o_strobe && !o_found, o_read_value == '1, "miss without all ones")
    `ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted word did not raise busy")
    `ASSERT_IMPLY(a_strobe_after_finish, o_strobe, $past(fin_get), "stray result strobe")
    `ASSERT_ALWAYS(a_count_bound, r_count <= CW'(ENTRIES), "entry count above depth")

endmodule
